// ----- src/lobm_pkg.sv -----
// Package with the order and result types, the state codes and the book sizes of the order matcher.
`timescale 1ns / 1ps
package lobm_pkg;
	localparam int BOOK_DEPTH = 32;
	localparam int PRICE_BITS = 32;
	localparam int QTY_BITS   = 32;
	localparam int IDX_W      = $clog2(BOOK_DEPTH);
	localparam int CNT_W      = $clog2(BOOK_DEPTH + 1);

	// Order kind and side codes
	localparam logic KIND_LIMIT  = 1'b0;
	localparam logic KIND_MARKET = 1'b1;
	localparam logic SIDE_BUY    = 1'b0;
	localparam logic SIDE_SELL   = 1'b1;

	typedef struct packed {
		logic                  kind;
		logic                  side;
		logic [PRICE_BITS-1:0] limit_price;
		logic [QTY_BITS-1:0]   quantity;
	} order_t;

	typedef struct packed {
		logic                  trade_valid;
		logic [PRICE_BITS-1:0] trade_price;
		logic [QTY_BITS-1:0]   trade_qty;
		logic                  rejected;
		logic                  last;
	} result_t;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_MATCH = 5'b00010,
		ST_REST  = 5'b00100,
		ST_SHIFT = 5'b01000,
		ST_FIN   = 5'b10000
	} state_t;
endpackage

// ----- src/limit_order_book_matcher_core.sv -----
// Top level of the price-priority limit order book matcher.
`timescale 1ns / 1ps
// Price-priority matcher with a bid and an ask book of BOOK_DEPTH entries each, kept as
// circular buffers sorted best first (oldest first among equal prices). One order is
// taken at a time: in_ready is high only between orders. Each fill uses the shared
// compare/subtract unit on the best opposite entry, and a resting remainder is placed by
// moving worse entries back one slot a cycle. Fills and the final result wait while
// out_ready is low and the output register is full. A finished result waits in the
// output register while the next order is accepted. No clearing pass follows reset.
module limit_order_book_matcher_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  lobm_pkg::order_t order,
	output logic             out_valid,
	input  logic             out_ready,
	output lobm_pkg::result_t result
);
	import lobm_pkg::*;

	// Book storage: book select 0 is the bid book, 1 the ask book
	logic [PRICE_BITS-1:0] bid_price_q [BOOK_DEPTH];
	logic [QTY_BITS-1:0]   bid_qty_q   [BOOK_DEPTH];
	logic [PRICE_BITS-1:0] ask_price_q [BOOK_DEPTH];
	logic [QTY_BITS-1:0]   ask_qty_q   [BOOK_DEPTH];
	logic [IDX_W-1:0]      head_q [2];
	logic [CNT_W-1:0]      cnt_q  [2];

	state_t                state_q;
	logic                  market_q, sell_q, rej_q;
	logic [PRICE_BITS-1:0] price_q;
	logic [QTY_BITS-1:0]   rem_q;
	logic [IDX_W-1:0]      idx_q;
	logic                  pend_v_q, out_valid_q;
	result_t               pend_q, out_q;

	logic                  own, opp, rd_book, slot_free, crosses, go_trade, worse;
	logic                  out_load;
	logic [IDX_W-1:0]      rd_addr, own_addr;
	logic [PRICE_BITS-1:0] rd_price;
	logic [QTY_BITS-1:0]   rd_qty, fill;
	logic                  wr_en, wr_book;
	logic [IDX_W-1:0]      wr_addr;
	logic [PRICE_BITS-1:0] wr_price;
	logic [QTY_BITS-1:0]   wr_qty;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign result    = out_q;

	// Read the best opposite entry or the entry ahead of the insert slot
	always_comb begin
		own       = sell_q;
		opp       = ~sell_q;
		own_addr  = head_q[own] + idx_q;
		rd_book   = (state_q == ST_SHIFT) ? own : opp;
		rd_addr   = (state_q == ST_SHIFT) ? own_addr - IDX_W'(1) : head_q[opp];
		rd_price  = rd_book ? ask_price_q[rd_addr] : bid_price_q[rd_addr];
		rd_qty    = rd_book ? ask_qty_q[rd_addr] : bid_qty_q[rd_addr];
		crosses   = market_q || (sell_q ? (rd_price >= price_q) : (price_q >= rd_price));
		go_trade  = (rem_q != '0) && (cnt_q[opp] != '0) && crosses;
		fill      = (rem_q < rd_qty) ? rem_q : rd_qty;
		worse     = (own == SIDE_BUY) ? (rd_price < price_q) : (rd_price > price_q);
		slot_free = !out_valid_q || out_ready;
		out_load  = slot_free && (((state_q == ST_MATCH) && go_trade && pend_v_q) ||
			(state_q == ST_FIN));
	end

	// Single write port into the books
	always_comb begin
		wr_en    = 1'b0;
		wr_book  = opp;
		wr_addr  = head_q[opp];
		wr_price = rd_price;
		wr_qty   = rd_qty - fill;
		unique case (state_q)
			ST_MATCH: wr_en = slot_free && go_trade && (fill != rd_qty);
			ST_SHIFT: begin
				wr_en   = 1'b1;
				wr_book = own;
				wr_addr = own_addr;
				if (idx_q != '0 && worse) begin
					wr_qty = rd_qty;
				end else begin
					wr_price = price_q;
					wr_qty   = rem_q;
				end
			end
			default: wr_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			if (wr_book) begin
				ask_price_q[wr_addr] <= wr_price;
				ask_qty_q[wr_addr]   <= wr_qty;
			end else begin
				bid_price_q[wr_addr] <= wr_price;
				bid_qty_q[wr_addr]   <= wr_qty;
			end
		end
	end

	// Sequencer: match, rest the remainder, deliver results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q[0]   <= '0;
			head_q[1]   <= '0;
			cnt_q[0]    <= '0;
			cnt_q[1]    <= '0;
			market_q    <= 1'b0;
			sell_q      <= 1'b0;
			rej_q       <= 1'b0;
			price_q     <= '0;
			rem_q       <= '0;
			idx_q       <= '0;
			pend_v_q    <= 1'b0;
			pend_q      <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			// Load the output register, or free it once taken
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						market_q <= (order.kind == KIND_MARKET);
						sell_q   <= (order.side == SIDE_SELL);
						price_q  <= order.limit_price;
						rem_q    <= order.quantity;
						rej_q    <= 1'b0;
						state_q  <= ST_MATCH;
					end
				end
				ST_MATCH: begin
					if (slot_free) begin
						if (go_trade) begin
							// flush the previous trade, hold this one until the next is known
							if (pend_v_q) begin
								out_q <= pend_q;
							end
							pend_v_q           <= 1'b1;
							pend_q.trade_valid <= 1'b1;
							pend_q.trade_price <= (sell_q && !market_q) ? price_q : rd_price;
							pend_q.trade_qty   <= fill;
							pend_q.rejected    <= 1'b0;
							pend_q.last        <= 1'b0;
							rem_q              <= rem_q - fill;
							if (fill == rd_qty) begin
								head_q[opp] <= head_q[opp] + IDX_W'(1);
								cnt_q[opp]  <= cnt_q[opp] - CNT_W'(1);
							end
						end else if (!market_q && rem_q != '0) begin
							state_q <= ST_REST;
						end else begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_REST: begin
					if (cnt_q[own] == CNT_W'(BOOK_DEPTH)) begin
						rej_q   <= 1'b1;
						state_q <= ST_FIN;
					end else begin
						idx_q   <= cnt_q[own][IDX_W-1:0];
						state_q <= ST_SHIFT;
					end
				end
				ST_SHIFT: begin
					// move a worse entry back, else drop the new order into the gap
					if (idx_q != '0 && worse) begin
						idx_q <= idx_q - IDX_W'(1);
					end else begin
						cnt_q[own] <= cnt_q[own] + CNT_W'(1);
						state_q    <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (slot_free) begin
						if (pend_v_q) begin
							out_q.trade_valid <= pend_q.trade_valid;
							out_q.trade_price <= pend_q.trade_price;
							out_q.trade_qty   <= pend_q.trade_qty;
							out_q.rejected    <= pend_q.rejected;
							out_q.last        <= !rej_q;
							pend_v_q          <= 1'b0;
							if (!rej_q) begin
								state_q <= ST_IDLE;
							end
						end else begin
							out_q.trade_valid <= 1'b0;
							out_q.trade_price <= '0;
							out_q.trade_qty   <= '0;
							out_q.rejected    <= rej_q;
							out_q.last        <= 1'b1;
							state_q           <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
